>>> hw/rtl/rrs_pkg.sv
`default_nettype none

package rrs_pkg;

	// Default configuration of the ring.
	localparam int DEPTH_DEF       = 10;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int HANDLE_BITS_DEF = 32;

	// Widths of the payload fields on the ports.
	localparam int HANDLE_FIELD_W = 32;
	localparam int LENGTH_FIELD_W = 16;
	localparam int OFFSET_FIELD_W = 20;

	// Item kinds.
	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_LK_RD,
		ST_LK_WALK
	} rrs_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // latch the incoming item
		logic rd_wr_idx; // read the slot at the write index
		logic rd_cur;    // read the slot at the walk pointer
		logic walk;      // step past the current record and read the next one
		logic res_add;   // commit the add and post its result
		logic res_hit;   // post a found result
		logic res_miss;  // post a not-found result
	} rrs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rem_zero; // no records left to walk
		logic rem_last; // the record being compared is the last stored one
		logic hit;      // the offset lies inside the record being compared
	} rrs_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/rrs_ctrl.sv
`default_nettype none

module rrs_ctrl
	import rrs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        kind,
	input  wire rrs_status_t status,
	output rrs_cmd_t         cmd,
	output logic             busy
);

	rrs_state_t state_q;
	rrs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (kind == KIND_LOOKUP) ? ST_LK_RD : ST_ADD_RD;
				end
			end
			ST_ADD_RD: begin
				state_d = ST_ADD_WR;
			end
			ST_ADD_WR: begin
				state_d = ST_IDLE;
			end
			ST_LK_RD: begin
				state_d = status.rem_zero ? ST_IDLE : ST_LK_WALK;
			end
			ST_LK_WALK: begin
				if (status.hit || status.rem_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_ADD_RD: begin
				cmd.rd_wr_idx = 1'b1;
			end
			ST_ADD_WR: begin
				cmd.res_add = 1'b1;
			end
			ST_LK_RD: begin
				cmd.rd_cur   = 1'b1;
				cmd.res_miss = status.rem_zero;
			end
			ST_LK_WALK: begin
				if (status.hit) begin
					cmd.res_hit = 1'b1;
				end else if (status.rem_last) begin
					cmd.res_miss = 1'b1;
				end else begin
					cmd.walk = 1'b1;
				end
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/rrs_dp.sv
`default_nettype none

module rrs_dp
	import rrs_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire rrs_cmd_t                  cmd,
	output rrs_status_t                    status,
	input  wire logic [HANDLE_FIELD_W-1:0] record_handle,
	input  wire logic [LENGTH_FIELD_W-1:0] record_length,
	input  wire logic [OFFSET_FIELD_W-1:0] lookup_offset,
	output logic                           done,
	output logic                           freed_valid,
	output logic [HANDLE_FIELD_W-1:0]      freed_handle,
	output logic                           found,
	output logic [HANDLE_FIELD_W-1:0]      found_handle,
	output logic [LENGTH_FIELD_W-1:0]      found_length,
	output logic [LENGTH_FIELD_W-1:0]      byte_in_record
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (LENGTH_BITS > OFFSET_FIELD_W) ? LENGTH_BITS : OFFSET_FIELD_W;
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(DEPTH - 1);

	// Record storage; valid bits make never-written slots read as zero.
	logic [HANDLE_BITS-1:0] handle_mem [DEPTH];
	logic [LENGTH_BITS-1:0] length_mem [DEPTH];
	logic [DEPTH-1:0]       valid_q;

	logic [IDX_W-1:0]          wr_idx_q;
	logic [IDX_W-1:0]          rd_idx_q;
	logic                      full_q;
	logic [IDX_W-1:0]          cur_q;
	logic [CNT_W-1:0]          rem_q;
	logic [OFFSET_FIELD_W-1:0] off_q;
	logic [HANDLE_BITS-1:0]    hdl_in_q;
	logic [LENGTH_BITS-1:0]    len_in_q;
	logic [HANDLE_BITS-1:0]    hdl_rd_q;
	logic [LENGTH_BITS-1:0]    len_rd_q;
	logic                      vld_rd_q;
	logic                      done_q;

	logic [IDX_W-1:0]       next_cur;
	logic [IDX_W-1:0]       next_wr;
	logic [IDX_W-1:0]       next_rd;
	logic [IDX_W-1:0]       rd_addr;
	logic                   rd_en;
	logic [CNT_W-1:0]       count;
	logic [CNT_W-1:0]       diff;
	logic [HANDLE_BITS-1:0] hdl_rd;
	logic [LENGTH_BITS-1:0] len_rd;
	logic                   hit;
	logic                   freed;

	assign next_cur = (cur_q == LAST_SLOT) ? '0 : cur_q + 1'b1;
	assign next_wr  = (wr_idx_q == LAST_SLOT) ? '0 : wr_idx_q + 1'b1;
	assign next_rd  = (rd_idx_q == LAST_SLOT) ? '0 : rd_idx_q + 1'b1;

	// Stored record count; the wrapped difference is corrected by DEPTH.
	assign diff  = CNT_W'(wr_idx_q) - CNT_W'(rd_idx_q);
	assign count = full_q ? CNT_W'(DEPTH)
		: ((wr_idx_q < rd_idx_q) ? diff + CNT_W'(DEPTH) : diff);

	assign rd_en   = cmd.rd_wr_idx | cmd.rd_cur | cmd.walk;
	assign rd_addr = cmd.rd_wr_idx ? wr_idx_q : (cmd.walk ? next_cur : cur_q);

	assign hdl_rd = vld_rd_q ? hdl_rd_q : '0;
	assign len_rd = vld_rd_q ? len_rd_q : '0;
	assign hit    = CMP_W'(off_q) < CMP_W'(len_rd);
	assign freed  = cmd.res_add & full_q;

	assign status.rem_zero = (rem_q == '0);
	assign status.rem_last = (rem_q == CNT_W'(1));
	assign status.hit      = hit;

	always_ff @(posedge clk) begin
		if (cmd.res_add) begin
			handle_mem[wr_idx_q] <= hdl_in_q;
			length_mem[wr_idx_q] <= len_in_q;
		end
		if (rd_en) begin
			hdl_rd_q <= handle_mem[rd_addr];
			len_rd_q <= length_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			full_q   <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= cmd.res_add | cmd.res_hit | cmd.res_miss;
			if (rd_en) begin
				vld_rd_q <= valid_q[rd_addr];
			end
			if (cmd.res_add) begin
				valid_q[wr_idx_q] <= 1'b1;
				wr_idx_q          <= next_wr;
				if (full_q) begin
					rd_idx_q <= next_rd;
				end
				full_q <= (next_wr == (full_q ? next_rd : rd_idx_q));
			end
		end
	end

	// Item and walk registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hdl_in_q <= HANDLE_BITS'(record_handle);
			len_in_q <= LENGTH_BITS'(record_length);
			off_q    <= lookup_offset;
			cur_q    <= rd_idx_q;
			rem_q    <= count;
		end else if (cmd.walk) begin
			off_q <= off_q - OFFSET_FIELD_W'(len_rd);
			cur_q <= next_cur;
			rem_q <= rem_q - 1'b1;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.res_add | cmd.res_hit | cmd.res_miss) begin
			freed_valid    <= freed;
			freed_handle   <= freed ? HANDLE_FIELD_W'(hdl_rd) : '0;
			found          <= cmd.res_hit;
			found_handle   <= cmd.res_hit ? HANDLE_FIELD_W'(hdl_rd) : '0;
			found_length   <= cmd.res_hit ? LENGTH_FIELD_W'(len_rd) : '0;
			byte_in_record <= cmd.res_hit ? LENGTH_FIELD_W'(off_q) : '0;
		end
	end

	assign done = done_q;

	a_full_idx: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |-> (wr_idx_q == rd_idx_q))
		else $error("ring full but write and read indexes differ");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_idx_q <= LAST_SLOT) && (rd_idx_q <= LAST_SLOT))
		else $error("ring index out of range");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.res_add, cmd.res_hit, cmd.res_miss}))
		else $error("more than one result posted for an item");

	a_strobe_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_walk_left: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> (rem_q > CNT_W'(1)))
		else $error("walk stepped past the stored records");

endmodule

`default_nettype wire

>>> hw/rtl/ring_record_store_offset_lookup_unit.sv
`default_nettype none

// Ring of DEPTH records (handle, length) that overwrites the oldest record
// when full and finds the record holding a character offset into the stored
// data, oldest first. An item is taken when start is high and busy is low;
// its result shows for one cycle with done high, and the receiver cannot
// stall it. An add reads the slot at the write index, then writes the record
// and posts its result. A lookup compares records until the match or the end
// of the stored data (at most DEPTH records); the record store has one read
// port and the walk compares one record per cycle. Busy falls in the cycle
// that done rises, so the next item may start then.
module ring_record_store_offset_lookup_unit
	import rrs_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic                      kind,
	input  wire logic [HANDLE_FIELD_W-1:0] record_handle,
	input  wire logic [LENGTH_FIELD_W-1:0] record_length,
	input  wire logic [OFFSET_FIELD_W-1:0] lookup_offset,
	output logic                           done,
	output logic                           freed_valid,
	output logic [HANDLE_FIELD_W-1:0]      freed_handle,
	output logic                           found,
	output logic [HANDLE_FIELD_W-1:0]      found_handle,
	output logic [LENGTH_FIELD_W-1:0]      found_length,
	output logic [LENGTH_FIELD_W-1:0]      byte_in_record
);

	rrs_cmd_t    cmd;
	rrs_status_t status;

	rrs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	rrs_dp #(
		.DEPTH       (DEPTH),
		.LENGTH_BITS (LENGTH_BITS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.record_handle  (record_handle),
		.record_length  (record_length),
		.lookup_offset  (lookup_offset),
		.done           (done),
		.freed_valid    (freed_valid),
		.freed_handle   (freed_handle),
		.found          (found),
		.found_handle   (found_handle),
		.found_length   (found_length),
		.byte_in_record (byte_in_record)
	);

endmodule

`default_nettype wire

>>> tb/sv/ring_record_store_offset_lookup_unit_checker.sv
`timescale 1ns / 100ps

module ring_record_store_offset_lookup_unit_checker
	import rrs_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      busy,
	input  wire logic                      kind,
	input  wire logic [HANDLE_FIELD_W-1:0] record_handle,
	input  wire logic [LENGTH_FIELD_W-1:0] record_length,
	input  wire logic [OFFSET_FIELD_W-1:0] lookup_offset,
	input  wire logic                      done,
	input  wire logic                      freed_valid,
	input  wire logic [HANDLE_FIELD_W-1:0] freed_handle,
	input  wire logic                      found,
	input  wire logic [HANDLE_FIELD_W-1:0] found_handle,
	input  wire logic [LENGTH_FIELD_W-1:0] found_length,
	input  wire logic [LENGTH_FIELD_W-1:0] byte_in_record,
	output int                             failures,
	output int                             pending
);

	localparam int RING_SLOTS = DEPTH_DEF;
	localparam int PRINT_CAP  = 60;

	typedef struct {
		bit                      freed_valid;
		bit [HANDLE_FIELD_W-1:0] freed_handle;
		bit                      found;
		bit [HANDLE_FIELD_W-1:0] found_handle;
		bit [LENGTH_FIELD_W-1:0] found_length;
		bit [LENGTH_FIELD_W-1:0] byte_in_record;
	} ring_result_t;

	ring_result_t            outstanding_results[$];
	ring_result_t            oldest;
	bit [HANDLE_FIELD_W-1:0] handle_ring [RING_SLOTS];
	bit [LENGTH_FIELD_W-1:0] length_ring [RING_SLOTS];
	int unsigned             write_slot;
	int unsigned             oldest_slot;
	bit                      ring_is_full;
	int                      fail_tally = 0;

	function automatic int unsigned next_slot(input int unsigned slot);
		return (slot >= RING_SLOTS - 1) ? 0 : slot + 1;
	endfunction

	// Applies one item to the shadow ring and returns the result it should give.
	function automatic ring_result_t apply_item(
		input logic                      item_kind,
		input logic [HANDLE_FIELD_W-1:0] handle_in,
		input logic [LENGTH_FIELD_W-1:0] length_in,
		input logic [OFFSET_FIELD_W-1:0] offset_in
	);
		ring_result_t    res;
		longint unsigned remaining;
		int unsigned     cur;
		int unsigned     records;
		bit              hit;
		res = '{default: '0};
		if (item_kind == KIND_ADD) begin
			if (ring_is_full) begin
				res.freed_valid  = 1'b1;
				res.freed_handle = handle_ring[write_slot];
				oldest_slot      = next_slot(oldest_slot);
			end
			handle_ring[write_slot] = handle_in;
			length_ring[write_slot] = length_in;
			write_slot   = next_slot(write_slot);
			ring_is_full = (write_slot == oldest_slot);
		end else begin
			remaining = 64'(offset_in);
			cur       = oldest_slot;
			hit       = 1'b0;
			records   = ring_is_full ? RING_SLOTS :
				(write_slot + RING_SLOTS - oldest_slot) % RING_SLOTS;
			// Zero-length records never satisfy the compare, so the walk steps over them.
			for (int n = 0; n < records && !hit; n++) begin
				if (remaining < 64'(length_ring[cur])) begin
					hit                = 1'b1;
					res.found          = 1'b1;
					res.found_handle   = handle_ring[cur];
					res.found_length   = length_ring[cur];
					res.byte_in_record = remaining[LENGTH_FIELD_W-1:0];
				end else begin
					remaining -= 64'(length_ring[cur]);
					cur = next_slot(cur);
				end
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_tally < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
		fail_tally++;
	endtask

	task automatic compare_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got)
			report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (handle_ring[i]) begin
				handle_ring[i] = '0;
				length_ring[i] = '0;
			end
			write_slot   = 0;
			oldest_slot  = 0;
			ring_is_full = 1'b0;
			outstanding_results.delete();
			failures <= fail_tally;
			pending  <= 0;
		end else begin
			// A result always belongs to an item taken at an earlier edge.
			if (done) begin
				if (outstanding_results.size() == 0) begin
					report_mismatch("result with no item outstanding");
				end else begin
					oldest = outstanding_results.pop_front();
					compare_field("freed_valid", 64'(oldest.freed_valid),
						64'(freed_valid));
					compare_field("freed_handle", 64'(oldest.freed_handle),
						64'(freed_handle));
					compare_field("found", 64'(oldest.found), 64'(found));
					compare_field("found_handle", 64'(oldest.found_handle),
						64'(found_handle));
					compare_field("found_length", 64'(oldest.found_length),
						64'(found_length));
					compare_field("byte_in_record", 64'(oldest.byte_in_record),
						64'(byte_in_record));
				end
			end
			if (start && !busy)
				outstanding_results.push_back(apply_item(kind, record_handle,
					record_length, lookup_offset));
			failures <= fail_tally;
			pending  <= outstanding_results.size();
		end
	end

endmodule

>>> tb/sv/ring_record_store_offset_lookup_unit_tb.sv
`timescale 1ns / 100ps

module ring_record_store_offset_lookup_unit_tb;
	import rrs_pkg::*;

	localparam int RANDOM_ITEMS = 650;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = DEPTH_DEF + 10;

	logic                      clk;
	logic                      arst_n         = 1'b0;
	logic                      start          = 1'b0;
	logic                      kind           = KIND_ADD;
	logic [HANDLE_FIELD_W-1:0] record_handle  = '0;
	logic [LENGTH_FIELD_W-1:0] record_length  = '0;
	logic [OFFSET_FIELD_W-1:0] lookup_offset  = '0;
	logic                      busy;
	logic                      done;
	logic                      freed_valid;
	logic [HANDLE_FIELD_W-1:0] freed_handle;
	logic                      found;
	logic [HANDLE_FIELD_W-1:0] found_handle;
	logic [LENGTH_FIELD_W-1:0] found_length;
	logic [LENGTH_FIELD_W-1:0] byte_in_record;
	int                        failures;
	int                        pending;
	int                        cycle_count = 0;

	ring_record_store_offset_lookup_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.record_handle  (record_handle),
		.record_length  (record_length),
		.lookup_offset  (lookup_offset),
		.done           (done),
		.freed_valid    (freed_valid),
		.freed_handle   (freed_handle),
		.found          (found),
		.found_handle   (found_handle),
		.found_length   (found_length),
		.byte_in_record (byte_in_record)
	);

	ring_record_store_offset_lookup_unit_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.record_handle  (record_handle),
		.record_length  (record_length),
		.lookup_offset  (lookup_offset),
		.done           (done),
		.freed_valid    (freed_valid),
		.freed_handle   (freed_handle),
		.found          (found),
		.found_handle   (found_handle),
		.found_length   (found_length),
		.byte_in_record (byte_in_record),
		.failures       (failures),
		.pending        (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// Presents one item, holds it until taken, then idles for the given cycles.
	// Start stays high when there is no gap so the next item follows directly.
	task automatic send_item(input logic item_kind, input logic [HANDLE_FIELD_W-1:0] h,
			input logic [LENGTH_FIELD_W-1:0] len, input logic [OFFSET_FIELD_W-1:0] off,
			input int gap);
		start         <= 1'b1;
		kind          <= item_kind;
		record_handle <= h;
		record_length <= len;
		lookup_offset <= off;
		do @(posedge clk); while (busy);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lowers start and waits until every outstanding result has arrived.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic                      item_kind;
		logic [HANDLE_FIELD_W-1:0] h;
		logic [LENGTH_FIELD_W-1:0] len;
		logic [OFFSET_FIELD_W-1:0] off;
		int                        gap;
		bit                        quiet;
		int unsigned               pick;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lookups on an empty ring, then a zero-length record that must be skipped.
		send_item(KIND_LOOKUP, '0, '0, '0, 0);
		send_item(KIND_LOOKUP, '0, '0, '1, 2);
		send_item(KIND_ADD, '0, '0, '0, 0);
		send_item(KIND_LOOKUP, '0, '0, '0, 1);
		// Largest record: first byte, last byte, and one past the end.
		send_item(KIND_ADD, '1, '1, '0, 0);
		send_item(KIND_LOOKUP, '0, '0, 20'h00000, 0);
		send_item(KIND_LOOKUP, '0, '0, 20'h0FFFE, 3);
		send_item(KIND_LOOKUP, '0, '0, 20'h0FFFF, 0);
		send_item(KIND_ADD, 32'hA5A5A5A5, 16'd1, '0, 0);
		send_item(KIND_LOOKUP, '0, '0, 20'h0FFFF, 0);
		send_item(KIND_LOOKUP, '0, '0, 20'h10000, 1);
		// Fill the ring and then overwrite the two oldest records.
		for (int i = 0; i < 9; i++)
			send_item(KIND_ADD, 32'h11111111 * (i + 1), 16'(i + 2), '0, i % 3);
		send_item(KIND_LOOKUP, '0, '0, '1, 0);
		send_item(KIND_LOOKUP, '0, '0, '0, 0);
		drain_results();

		quiet = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_ITEMS / 2)
				drain_results();

			item_kind = ($urandom_range(0, 99) < 45) ? KIND_ADD : KIND_LOOKUP;
			h         = $urandom();
			pick      = $urandom_range(0, 99);
			if (pick < 55)
				len = LENGTH_FIELD_W'($urandom_range(0, 12));
			else if (pick < 63)
				len = '0;
			else if (pick < 70)
				len = '1;
			else
				len = LENGTH_FIELD_W'($urandom());

			// Small offsets land in rings of short records; the wider ranges
			// reach rings that hold long ones, and past the end of the data.
			pick = $urandom_range(0, 99);
			if (pick < 45)
				off = OFFSET_FIELD_W'($urandom_range(0, 120));
			else if (pick < 75)
				off = OFFSET_FIELD_W'($urandom_range(0, 700000));
			else
				off = OFFSET_FIELD_W'($urandom());

			gap = quiet ? 0 : int'($urandom_range(0, 7));
			send_item(item_kind, h, len, off, gap);
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_ctrl.sv
hw/rtl/rrs_dp.sv
hw/rtl/ring_record_store_offset_lookup_unit.sv
tb/sv/ring_record_store_offset_lookup_unit_checker.sv
tb/sv/ring_record_store_offset_lookup_unit_tb.sv
